/* hdl/cbs_pkg.sv */
// shared types and constants for the code block segmenter with per-block crc24b
// no dependencies; imported by every module of the block
package cbs_pkg;

  localparam int CRC_WIDTH   = 24;
  localparam int CRC_IDX_W   = 5;
  localparam int LEN_W       = 14;
  localparam int BLK_W       = 8;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // x^24+x^23+x^6+x^5+x+1 without the leading term
  localparam logic [CRC_WIDTH-1:0] CRC_POLY = 24'h800063;

  // item_kind codes
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_CRC  = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd3;

  typedef struct packed {
    logic             crc_enable;
    logic [LEN_W-1:0] data_bits;
    logic [LEN_W-1:0] filler_bits;
    logic [BLK_W-1:0] num_blocks;
  } cfg_t;

  // one classified input bit, as handed from front to back
  typedef struct packed {
    logic                 data_bit;
    logic [BLK_W-1:0]     blk;
    logic                 close;
    logic                 attach_crc;
    logic [CRC_WIDTH-1:0] crc;
    logic [LEN_W-1:0]     filler;
  } qentry_t;

endpackage

/* hdl/cbs_front.sv */
// front end: configuration registers, bit counter, running crc24b and block counter
// depends on cbs_pkg; pushes one classified entry per accepted bit into cbs_queue
module cbs_front
  import cbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  data_bit,
  output logic                  push,
  output qentry_t               push_entry
);

  cfg_t                 cfg;
  logic [LEN_W-1:0]     bit_position;
  logic [CRC_WIDTH-1:0] crc_register;
  logic [BLK_W-1:0]     current_block;

  logic [LEN_W-1:0]     len;
  logic [BLK_W-1:0]     nblk;
  logic                 close;
  logic                 last_blk;
  logic                 fb;
  logic [CRC_WIDTH-1:0] crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_enable  <= 1'b0;
      cfg.data_bits   <= LEN_W'(8424);
      cfg.filler_bits <= '0;
      cfg.num_blocks  <= BLK_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CRC_ENABLE: cfg.crc_enable  <= cfg_data[0];
        CFG_DATA_BITS:  cfg.data_bits   <= cfg_data[LEN_W-1:0];
        CFG_FILLER:     cfg.filler_bits <= cfg_data[LEN_W-1:0];
        CFG_NUM_BLOCKS: cfg.num_blocks  <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len      = (cfg.data_bits == '0) ? LEN_W'(1) : cfg.data_bits;
    nblk     = (cfg.num_blocks == '0) ? BLK_W'(1) : cfg.num_blocks;
    close    = ({1'b0, bit_position} + (LEN_W+1)'(1)) >= {1'b0, len};
    last_blk = ({1'b0, current_block} + (BLK_W+1)'(1)) >= {1'b0, nblk};
    fb       = data_bit ^ crc_register[CRC_WIDTH-1];
    crc_next = {crc_register[CRC_WIDTH-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  end

  assign push                  = in_valid && in_ready;
  assign push_entry.data_bit   = data_bit;
  assign push_entry.blk        = current_block;
  assign push_entry.close      = close;
  assign push_entry.attach_crc = cfg.crc_enable && (nblk > BLK_W'(1));
  assign push_entry.crc        = crc_next;
  assign push_entry.filler     = cfg.filler_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position  <= '0;
      crc_register  <= '0;
      current_block <= '0;
    end else if (push) begin
      if (close) begin
        bit_position  <= '0;
        crc_register  <= '0;
        current_block <= last_blk ? '0 : current_block + BLK_W'(1);
      end else begin
        bit_position  <= bit_position + LEN_W'(1);
        crc_register  <= crc_next;
      end
    end
  end

endmodule

/* hdl/cbs_queue.sv */
// short queue of classified entries between front and back
// depends on cbs_pkg; head entry is shown as soon as it is stored
module cbs_queue
  import cbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_entry,
  output logic    not_full,
  input  logic    pop,
  output logic    head_valid,
  output qentry_t head
);

  qentry_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign not_full   = count != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/cbs_back.sv */
// back end: expands each queue entry into result items, one per cycle as
// out_ready allows; depends on cbs_pkg; drives the result output register
module cbs_back
  import cbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  qentry_t          head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_bit,
  output logic [1:0]       item_kind,
  output logic [LEN_W-1:0] filler_count,
  output logic [BLK_W-1:0] block_index,
  output logic             block_end,
  output logic             run_last
);

  typedef enum logic [2:0] {
    ST_DATA = 3'b001,
    ST_CRC  = 3'b010,
    ST_FILL = 3'b100
  } back_state_t;

  back_state_t          state, state_next;
  logic [CRC_IDX_W-1:0] crc_cnt, crc_cnt_next;
  logic                 load;

  logic             r_bit;
  logic [1:0]       r_kind;
  logic [LEN_W-1:0] r_fill;
  logic             r_end;
  logic             r_last;

  assign load = head_valid && (!out_valid || out_ready);

  always_comb begin
    state_next   = state;
    crc_cnt_next = crc_cnt;
    pop          = 1'b0;
    r_bit        = 1'b0;
    r_kind       = KIND_DATA;
    r_fill       = '0;
    r_end        = 1'b0;
    r_last       = 1'b0;
    unique case (state)
      ST_DATA: begin
        r_bit  = head.data_bit;
        r_last = !head.close;
        if (load) begin
          if (!head.close)          pop        = 1'b1;
          else if (head.attach_crc) state_next = ST_CRC;
          else                      state_next = ST_FILL;
        end
      end
      ST_CRC: begin
        r_bit  = head.crc[CRC_IDX_W'(CRC_WIDTH-1) - crc_cnt];
        r_kind = KIND_CRC;
        if (load) begin
          if (crc_cnt == CRC_IDX_W'(CRC_WIDTH-1)) begin
            crc_cnt_next = '0;
            state_next   = ST_FILL;
          end else begin
            crc_cnt_next = crc_cnt + CRC_IDX_W'(1);
          end
        end
      end
      ST_FILL: begin
        r_kind = KIND_FILL;
        r_fill = head.filler;
        r_end  = 1'b1;
        r_last = 1'b1;
        if (load) begin
          pop        = 1'b1;
          state_next = ST_DATA;
        end
      end
      default: state_next = ST_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DATA;
      crc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      crc_cnt   <= crc_cnt_next;
      out_valid <= head_valid || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bit      <= r_bit;
      item_kind    <= r_kind;
      filler_count <= r_fill;
      block_index  <= head.blk;
      block_end    <= r_end;
      run_last     <= r_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_crc_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DATA) |-> head_valid)
    else $error("parity or filler phase without a queue entry");

  a_cnt_only_in_crc: assert property (@(posedge clk) disable iff (rst)
    (crc_cnt != '0) |-> (state == ST_CRC))
    else $error("parity counter running outside the parity phase");

  a_fill_closes_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_FILL) |-> (block_end && run_last))
    else $error("filler item does not close block and run");

  a_crc_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_CRC) |-> (!run_last && !block_end))
    else $error("parity bit marked as last");
`endif

endmodule

/* hdl/code_block_segmenter_crc24b.sv */
// top level of the code block segmenter with per-block crc24b
// depends on cbs_pkg, cbs_front, cbs_queue and cbs_back
//
// takes the crc-attached transport block one bit per transfer and cuts it into
// code blocks. every bit comes out as a data item and is folded into a running
// crc24b (zero start, msb first). when a block's data bits are complete, the 24
// parity bits follow if block crc is on and there is more than one block, then
// one filler-run item that carries filler_bits and marks block_end. run_last
// marks the last result caused by one input bit. the result channel moves one
// item per cycle while out_ready stays high, set by the back end's single output
// register; an input bit that does not close a block yields one result item, so
// bits stream at one per cycle while out_ready stays high. a closing bit expands
// into 2 or 26 result items, one per cycle as out_ready allows, while the front
// keeps taking bits into a four-entry queue until it fills and in_ready drops.
// configuration writes take effect on the next input bit and do not clear the
// running state; write them only while idle.
module code_block_segmenter_crc24b
  import cbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input bit channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  data_bit,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bit,
  output logic [1:0]            item_kind,
  output logic [LEN_W-1:0]      filler_count,
  output logic [BLK_W-1:0]      block_index,
  output logic                  block_end,
  output logic                  run_last
);

  // front to queue
  logic    push;
  qentry_t push_entry;
  // queue to back
  logic    head_valid;
  qentry_t head;
  logic    pop;

  // counters, crc and config live in the front; it runs whenever the queue has room
  cbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_bit   (data_bit),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the bit stream from the parity tail expansion
  cbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // walks data, parity and filler phases for the head entry
  cbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bit      (out_bit),
    .item_kind    (item_kind),
    .filler_count (filler_count),
    .block_index  (block_index),
    .block_end    (block_end),
    .run_last     (run_last)
  );

endmodule

/* sim/code_block_segmenter_crc24b_tb.sv */
// testbench for code_block_segmenter_crc24b: random bit streams over many block setups
// depends on cbs_pkg and the segmenter rtl; self-checking against an internal predictor
module code_block_segmenter_crc24b_tb;
  import cbs_pkg::*;

  // one result transfer as seen on the output channel
  typedef struct packed {
    logic             out_bit;
    logic [1:0]       kind;
    logic [LEN_W-1:0] filler;
    logic [BLK_W-1:0] blk;
    logic             blk_end;
    logic             run_last;
  } seg_item_t;

  // receiver behavior, switched to a random mode whenever its hold time runs out
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_STARVE} rx_mode_t;

  // tracks the segmenter state (block position, crc24b, block counter) and
  // holds the result items that each accepted bit must produce
  class segment_checker;
    int unsigned crc_en    = 0;
    int unsigned data_bits = 8424;
    int unsigned filler    = 0;
    int unsigned blocks    = 1;

    int unsigned          pos     = 0;
    logic [CRC_WIDTH-1:0] crc     = '0;
    int unsigned          cur_blk = 0;

    seg_item_t expected_items[$];
    int        failures = 0;
    int        reported = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CRC_ENABLE: crc_en    = 32'(val[0]);
        CFG_DATA_BITS:  data_bits = 32'(val);
        CFG_FILLER:     filler    = 32'(val);
        CFG_NUM_BLOCKS: blocks    = 32'(val[BLK_W-1:0]);
        default: ;
      endcase
    endfunction

    function void take_bit(logic b);
      int unsigned      len;
      int unsigned      nblk;
      logic             closing;
      logic [BLK_W-1:0] blk;
      int               i;
      blk  = cur_blk[BLK_W-1:0];
      len  = (data_bits == 0) ? 1 : data_bits;
      nblk = (blocks == 0) ? 1 : blocks;
      closing = (pos + 1 >= len);
      // fold the bit in, msb first, feedback from the top bit
      if (b ^ crc[CRC_WIDTH-1])
        crc = {crc[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
      else
        crc = {crc[CRC_WIDTH-2:0], 1'b0};
      expected_items.push_back('{b, KIND_DATA, '0, blk, 1'b0, !closing});
      if (closing) begin
        if (crc_en != 0 && nblk > 1) begin
          for (i = CRC_WIDTH - 1; i >= 0; i--)
            expected_items.push_back('{crc[i], KIND_CRC, '0, blk, 1'b0, 1'b0});
        end
        expected_items.push_back('{1'b0, KIND_FILL, filler[LEN_W-1:0], blk, 1'b1, 1'b1});
        pos = 0;
        crc = '0;
        cur_blk = (cur_blk + 1 >= nblk) ? 0 : cur_blk + 1;
      end else begin
        pos++;
      end
    endfunction

    function void complain(string what, seg_item_t want, seg_item_t got);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("%s: want bit %0d kind %0d fill %0d blk %0d end %0d last %0d",
                 what, want.out_bit, want.kind, want.filler, want.blk, want.blk_end,
                 want.run_last);
        $display("    got  bit %0d kind %0d fill %0d blk %0d end %0d last %0d",
                 got.out_bit, got.kind, got.filler, got.blk, got.blk_end, got.run_last);
      end
    endfunction

    function void check_item(seg_item_t got);
      if (expected_items.size() == 0)
        complain("unexpected result", '0, got);
      else if (expected_items[0] != got)
        complain("result mismatch", expected_items.pop_front(), got);
      else
        void'(expected_items.pop_front());
    endfunction

    function int outstanding();
      return expected_items.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  data_bit;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_bit;
  logic [1:0]            item_kind;
  logic [LEN_W-1:0]      filler_count;
  logic [BLK_W-1:0]      block_index;
  logic                  block_end;
  logic                  run_last;

  segment_checker chk = new;

  code_block_segmenter_crc24b dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_bit     (data_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bit      (out_bit),
    .item_kind    (item_kind),
    .filler_count (filler_count),
    .block_index  (block_index),
    .block_end    (block_end),
    .run_last     (run_last)
  );

  always #4 clk = ~clk;

  // result monitor: every output transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      chk.check_item('{out_bit, item_kind, filler_count, block_index, block_end, run_last});
  end

  // receiver stall pattern, independent of the sender
  rx_mode_t    rx_mode  = RX_OPEN;
  int unsigned rx_hold  = 0;
  logic [1:0]  rx_phase = '0;

  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(16, 96);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    rx_phase <= rx_phase + 2'd1;
    case (rx_mode)
      RX_OPEN:        out_ready <= 1'b1;
      RX_COIN:        out_ready <= logic'($urandom_range(0, 1));
      RX_ONE_IN_FOUR: out_ready <= (rx_phase == 2'd0);
      default:        out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // register write, one cycle of write enable, then back to quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    chk.write_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // offer one bit and hold it until the transfer happens
  task automatic send_bit(input logic b);
    @(negedge clk);
    in_valid <= 1'b1;
    data_bit <= b;
    do @(posedge clk); while (!in_ready);
    chk.take_bit(b);
  endtask

  // sender gap, with in_valid held low for a length set by n
  task automatic idle(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending and let every expected result come out before touching registers
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.outstanding() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          i;
    int          sent;
    int          n_bits;
    int          burst_left;
    int unsigned pick;
    bit          gappy;
    logic [5:0]  pattern;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_bit  = 1'b0;
    pattern   = 6'b101101;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setup: 8424-bit blocks, so these bits only pass through
    send_bit(1'b1);
    send_bit(1'b0);
    drain();

    // shorten the block mid-way: the next bit closes it; filler at all ones
    write_reg(CFG_DATA_BITS, 14'd2);
    write_reg(CFG_FILLER, 14'h3FFF);
    send_bit(1'b1);
    drain();

    // zero length and zero block count: every bit closes, no parity, block 0
    write_reg(CFG_CRC_ENABLE, 14'd1);
    write_reg(CFG_DATA_BITS, 14'd0);
    write_reg(CFG_NUM_BLOCKS, 14'd0);
    write_reg(CFG_FILLER, 14'd0);
    send_bit(1'b0);
    send_bit(1'b1);
    drain();

    // one-bit blocks, 255 blocks: parity after each bit, block counter walks up
    write_reg(CFG_DATA_BITS, 14'd1);
    write_reg(CFG_NUM_BLOCKS, 14'd255);
    write_reg(CFG_FILLER, 14'd8448);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    drain();

    // block count lowered below the counter: wraps to zero at the next close
    write_reg(CFG_NUM_BLOCKS, 14'd2);
    write_reg(CFG_DATA_BITS, 14'd3);
    for (i = 0; i < 6; i++)
      send_bit(pattern[i]);
    drain();

    // longest lengths, a few bits each; the random part then cuts the block short
    write_reg(CFG_DATA_BITS, 14'h3FFF);
    for (i = 0; i < 6; i++)
      send_bit(logic'($urandom_range(0, 1)));
    drain();
    write_reg(CFG_DATA_BITS, 14'd8448);
    for (i = 0; i < 6; i++)
      send_bit(logic'($urandom_range(0, 1)));
    drain();

    // random phases: fresh setup, a burst of bits, then a full drain
    sent = 0;
    while (sent < 340) begin
      write_reg(CFG_CRC_ENABLE, 14'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      if (pick == 0)
        write_reg(CFG_DATA_BITS, 14'd0);
      else if (pick == 9)
        write_reg(CFG_DATA_BITS, 14'($urandom_range(31, 120)));
      else
        write_reg(CFG_DATA_BITS, 14'($urandom_range(1, 30)));
      pick = $urandom_range(0, 7);
      if (pick == 0)
        write_reg(CFG_NUM_BLOCKS, 14'd0);
      else if (pick == 1)
        write_reg(CFG_NUM_BLOCKS, 14'd255);
      else
        write_reg(CFG_NUM_BLOCKS, 14'($urandom_range(1, 6)));
      write_reg(CFG_FILLER, 14'($urandom_range(0, 16383)));

      n_bits = $urandom_range(20, 50);
      gappy  = ($urandom_range(0, 3) != 0);
      for (i = 0; i < n_bits; i++) begin
        send_bit(logic'($urandom_range(0, 1)));
        if (gappy) begin
          if (burst_left == 0) begin
            idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
          end else begin
            burst_left--;
          end
        end
      end
      sent += n_bits;
      drain();
    end

    // anything still waiting here never came out
    if (chk.outstanding() > 0) begin
      $display("%0d expected results never arrived", chk.outstanding());
      chk.failures += chk.outstanding();
    end
    if (chk.failures == 0)
      $display("code_block_segmenter_crc24b_tb: clean");
    else
      $display("code_block_segmenter_crc24b_tb: errors");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("code_block_segmenter_crc24b_tb: errors");
    $finish;
  end

endmodule
